// ----- rtl/core/recursive_mutex_pool_assert.svh -----
// Assertion macros for the recursive mutex pool, empty in synthesis.
`ifndef RECURSIVE_MUTEX_POOL_ASSERT_SVH
`define RECURSIVE_MUTEX_POOL_ASSERT_SVH
`ifndef SYNTHESIS
// Implication property, sampled on clk_i and held off during reset.
`define RMP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("recursive_mutex_pool assertion failed");
// Condition that must never hold, sampled on clk_i and held off during reset.
`define RMP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("recursive_mutex_pool forbidden condition");
`else
`define RMP_ASSERT(lbl, prop)
`define RMP_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- rtl/core/rmp_pkg.sv -----
// Shared types and constants of the recursive mutex pool.
package rmp_pkg;

  localparam int OP_W     = 3;
  localparam int KIND_W   = 4;
  localparam int HANDLE_W = 6;
  localparam int TID_W    = 8;
  localparam int STATUS_W = 2;

  localparam int POOL_SLOTS_DEF   = 32;
  localparam int STATIC_SLOTS_DEF = 12;
  localparam int THREAD_BITS_DEF  = 8;
  localparam int DEPTH_BITS_DEF   = 8;

  localparam logic [KIND_W-1:0] KIND_FAST         = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_RECURSIVE    = KIND_W'(1);
  localparam logic [KIND_W-1:0] STATIC_FIRST_KIND = KIND_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_LOCK   = 3'd2,
    OP_UNLOCK = 3'd3,
    OP_HELD   = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BUSY      = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_MISUSE    = 2'd3
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
    logic [TID_W-1:0]    thread_id;
  } rmp_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic                held;
  } rmp_rsp_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic exec;
  } rmp_cmd_t;

endpackage

// ----- rtl/core/rmp_ctrl.sv -----
// Sequencer of the recursive mutex pool: capture, entry read, update.
module rmp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  output logic             done_o,
  output rmp_pkg::rmp_cmd_t cmd_o
);
  import rmp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == S_EXEC);
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_READ;
          end
        end
        S_READ:  state_q <= S_EXEC;
        S_EXEC:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign cmd_o.capture = start_i && (state_q == S_IDLE);
  assign cmd_o.read    = (state_q == S_READ);
  assign cmd_o.exec    = (state_q == S_EXEC);

endmodule

// ----- rtl/core/rmp_datapath.sv -----
// Entry store, pool allocation map and per-operation update of the mutex pool.
module rmp_datapath #(
  parameter int POOL_SLOTS   = rmp_pkg::POOL_SLOTS_DEF,
  parameter int STATIC_SLOTS = rmp_pkg::STATIC_SLOTS_DEF,
  parameter int THREAD_BITS  = rmp_pkg::THREAD_BITS_DEF,
  parameter int DEPTH_BITS   = rmp_pkg::DEPTH_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rmp_pkg::rmp_cmd_t cmd_i,
  input  rmp_pkg::rmp_req_t req_i,
  output rmp_pkg::rmp_rsp_t rsp_o
);
  import rmp_pkg::*;

  localparam int TOTAL_SLOTS = POOL_SLOTS + STATIC_SLOTS;
  localparam int IDX_W       = $clog2(TOTAL_SLOTS);
  localparam int SLOT_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CMP_W       = ((IDX_W > HANDLE_W) ? IDX_W : HANDLE_W) + 1;
  localparam int SCMP_W      = 7;
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  typedef struct packed {
    logic                   lock;
    logic [THREAD_BITS-1:0] owner;
    logic [DEPTH_BITS-1:0]  depth;
    logic                   rec;
  } entry_t;

  rmp_req_t               req_q;
  rmp_rsp_t               rsp_q;
  rmp_rsp_t               rsp_d;
  entry_t                 mem_q [TOTAL_SLOTS];
  logic [TOTAL_SLOTS-1:0] valid_q;
  logic [POOL_SLOTS-1:0]  slot_q;
  entry_t                 cur_q;
  logic [IDX_W-1:0]       addr_q;

  logic [THREAD_BITS-1:0] me;
  logic [KIND_W-1:0]      kind_off;
  logic                   static_ok;
  logic [IDX_W-1:0]       static_addr;
  logic                   pool_alloc;
  logic [CMP_W-1:0]       h_wide;
  logic                   in_range;
  logic [IDX_W-1:0]       rd_addr;
  logic                   free_found;
  logic [SLOT_W-1:0]      free_idx;
  entry_t                 nxt;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic                   slot_set;
  logic                   slot_clr;
  logic                   owned;

  // Request decode
  assign me          = THREAD_BITS'(req_q.thread_id);
  assign kind_off    = req_q.kind - STATIC_FIRST_KIND;
  assign static_ok   = {{(SCMP_W-KIND_W){1'b0}}, kind_off} < SCMP_W'(STATIC_SLOTS);
  assign static_addr = IDX_W'(POOL_SLOTS) + (static_ok ? IDX_W'(kind_off) : '0);
  assign pool_alloc  = (req_q.kind <= KIND_RECURSIVE);
  assign h_wide      = CMP_W'(req_q.handle);
  assign in_range    = (h_wide < CMP_W'(TOTAL_SLOTS));

  always_comb begin
    if (req_q.operation == OP_ALLOC) begin
      rd_addr = pool_alloc ? '0 : static_addr;
    end else begin
      rd_addr = in_range ? IDX_W'(h_wide) : '0;
    end
  end

  // Lowest free pool slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (!slot_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign owned = cur_q.lock && (cur_q.owner == me);

  always_comb begin
    nxt              = cur_q;
    wr_en            = 1'b0;
    wr_addr          = addr_q;
    slot_set         = 1'b0;
    slot_clr         = 1'b0;
    rsp_d.status     = ST_OK;
    rsp_d.handle_out = req_q.handle;
    rsp_d.held       = 1'b0;
    priority if (req_q.operation == OP_ALLOC) begin
      if (pool_alloc) begin
        if (free_found) begin
          nxt              = '0;
          nxt.rec          = (req_q.kind == KIND_RECURSIVE);
          wr_en            = 1'b1;
          wr_addr          = IDX_W'(free_idx);
          slot_set         = 1'b1;
          rsp_d.handle_out = HANDLE_W'(free_idx);
        end else begin
          rsp_d.status = ST_EXHAUSTED;
        end
      end else begin
        nxt.rec          = 1'b1;
        wr_en            = 1'b1;
        rsp_d.handle_out = HANDLE_W'(addr_q);
        rsp_d.held       = owned;
      end
    end else if ((req_q.operation > OP_HELD) || !in_range) begin
      rsp_d.status = ST_MISUSE;
    end else begin
      unique case (req_q.operation)
        OP_FREE: begin
          slot_clr = (addr_q < IDX_W'(POOL_SLOTS));
        end
        OP_LOCK: begin
          if (cur_q.rec && owned) begin
            if (cur_q.depth == DEPTH_MAX) begin
              rsp_d.status = ST_MISUSE;
            end else begin
              nxt.depth = cur_q.depth + DEPTH_BITS'(1);
              wr_en     = 1'b1;
            end
          end else if (!cur_q.lock) begin
            nxt.lock  = 1'b1;
            nxt.owner = me;
            nxt.depth = DEPTH_BITS'(1);
            wr_en     = 1'b1;
          end else begin
            rsp_d.status = ST_BUSY;
          end
        end
        OP_UNLOCK: begin
          if (!owned) begin
            rsp_d.status = ST_MISUSE;
          end else if (cur_q.depth > DEPTH_BITS'(1)) begin
            nxt.depth = cur_q.depth - DEPTH_BITS'(1);
            wr_en     = 1'b1;
          end else begin
            nxt.lock  = 1'b0;
            nxt.owner = '0;
            nxt.depth = '0;
            wr_en     = 1'b1;
          end
        end
        default: begin
        end
      endcase
      rsp_d.held = nxt.lock && (nxt.owner == me);
    end
  end

  // Request capture, entry read and result hold
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.read) begin
      addr_q <= rd_addr;
      cur_q  <= valid_q[rd_addr] ? mem_q[rd_addr] : '0;
    end
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem_q[wr_addr] <= nxt;
    end
  end

  // Entry valid bits and pool allocation map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      slot_q  <= '0;
    end else if (cmd_i.exec) begin
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (slot_set) begin
        slot_q[free_idx] <= 1'b1;
      end
      if (slot_clr) begin
        slot_q[addr_q[SLOT_W-1:0]] <= 1'b0;
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ----- rtl/core/recursive_mutex_pool.sv -----
// Top level of the recursive mutex pool lock manager.
//
// Use: drive req_i and raise start; the item is taken at a rising edge with
// start high and busy low. Operations are alloc, free, try-lock, unlock and
// held query; a blocking lock is built by the requester retrying try-lock.
// Each item yields exactly one result on rsp_o, marked by done_o for a
// single cycle. The receiver cannot stall: it must take the result then.
//
// Each item passes through the entry store sequence (capture, registered
// read of the entry, update and write back), and no new item is taken
// before it is through. busy drops in the cycle that presents the result,
// so the next item may be accepted at the same edge that takes the result.
//
// Reset (rst_ni low, asynchronous) empties the pool and unlocks every entry
// at once through per-entry valid bits; no clearing pass is needed and the
// block accepts items from the first cycle after reset.
`include "recursive_mutex_pool_assert.svh"
module recursive_mutex_pool #(
  parameter int POOL_SLOTS   = rmp_pkg::POOL_SLOTS_DEF,
  parameter int STATIC_SLOTS = rmp_pkg::STATIC_SLOTS_DEF,
  parameter int THREAD_BITS  = rmp_pkg::THREAD_BITS_DEF,
  parameter int DEPTH_BITS   = rmp_pkg::DEPTH_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rmp_pkg::rmp_req_t req_i,
  output logic              done_o,
  output rmp_pkg::rmp_rsp_t rsp_o
);
  import rmp_pkg::*;

  rmp_cmd_t cmd;

  // Sequence each item through capture, read and update
  rmp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // Hold the entry store, allocation map and result register
  rmp_datapath #(
    .POOL_SLOTS   (POOL_SLOTS),
    .STATIC_SLOTS (STATIC_SLOTS),
    .THREAD_BITS  (THREAD_BITS),
    .DEPTH_BITS   (DEPTH_BITS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

  // An accepted item keeps the block busy while it is worked on
  `RMP_ASSERT(a_accept_busy, start && !busy |=> busy && cmd.read)
  // Every accepted item is followed by its result strobe on done_o
  `RMP_ASSERT(a_accept_done, start && !busy |-> ##3 done_o)
  // A result strobe lasts one cycle only
  `RMP_ASSERT(a_done_single, done_o |=> !done_o)
  // Never capture a new item while an entry is being read or updated
  `RMP_ASSERT_NEVER(a_no_overlap, cmd.capture && (cmd.read || cmd.exec))

endmodule

// ----- dv/recursive_mutex_pool_checker.sv -----
// Checker for the recursive mutex pool: predicts each result and compares it.
module recursive_mutex_pool_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  rmp_pkg::rmp_req_t req_i,
  input  logic              done_i,
  input  rmp_pkg::rmp_rsp_t rsp_i,
  output int                fail_count_o,
  output int                outstanding_o
);
  import rmp_pkg::*;

  localparam int unsigned POOL    = POOL_SLOTS_DEF;
  localparam int unsigned STATICS = STATIC_SLOTS_DEF;
  localparam int unsigned ENTRIES = POOL_SLOTS_DEF + STATIC_SLOTS_DEF;
  localparam int unsigned DEPTH_MAX = (1 << DEPTH_BITS_DEF) - 1;
  localparam logic [TID_W-1:0] TID_MASK = TID_W'((1 << THREAD_BITS_DEF) - 1);

  // Shadow copy of the entry store.
  logic                      in_use_q    [ENTRIES] = '{default: 1'b0};
  logic                      taken_q     [ENTRIES] = '{default: 1'b0};
  logic [TID_W-1:0]          owner_q     [ENTRIES] = '{default: '0};
  logic [DEPTH_BITS_DEF-1:0] depth_q     [ENTRIES] = '{default: '0};
  logic                      recursive_q [ENTRIES] = '{default: 1'b0};

  rmp_rsp_t expected_rsp_q [$];
  rmp_rsp_t want;
  int       fails   = 0;
  int       waiting = 0;

  assign fail_count_o  = fails;
  assign outstanding_o = waiting;

  function automatic logic owns(input int unsigned e, input logic [TID_W-1:0] me);
    return taken_q[e] && owner_q[e] == me;
  endfunction

  function automatic rmp_rsp_t predict_outcome(input rmp_req_t r);
    rmp_rsp_t         o;
    logic [TID_W-1:0] me;
    int unsigned      h;
    int unsigned      e;
    int unsigned      idx;
    int               found;
    me           = r.thread_id & TID_MASK;
    h            = 32'(r.handle);
    o.status     = ST_OK;
    o.handle_out = r.handle;
    o.held       = 1'b0;
    if (r.operation == OP_ALLOC) begin
      if (r.kind == KIND_FAST || r.kind == KIND_RECURSIVE) begin
        found = -1;
        for (int i = POOL - 1; i >= 0; i--) if (!in_use_q[i]) found = i;
        if (found < 0) begin
          o.status = ST_EXHAUSTED;
        end else begin
          in_use_q[found]    = 1'b1;
          taken_q[found]     = 1'b0;
          owner_q[found]     = '0;
          depth_q[found]     = '0;
          recursive_q[found] = (r.kind == KIND_RECURSIVE);
          o.handle_out       = HANDLE_W'(found);
        end
      end else begin
        idx = 32'(r.kind) - 32'(STATIC_FIRST_KIND);
        if (idx >= STATICS) idx = 0;
        e              = POOL + idx;
        recursive_q[e] = 1'b1;
        in_use_q[e]    = 1'b1;
        o.handle_out   = HANDLE_W'(e);
        o.held         = owns(e, me);
      end
    end else if (r.operation > OP_HELD || h >= ENTRIES) begin
      o.status = ST_MISUSE;
    end else begin
      case (r.operation)
        OP_FREE: begin
          if (h < POOL) in_use_q[h] = 1'b0;
        end
        OP_LOCK: begin
          if (recursive_q[h] && owns(h, me)) begin
            if (depth_q[h] >= DEPTH_MAX) o.status = ST_MISUSE;
            else depth_q[h] = depth_q[h] + 1'b1;
          end else if (!taken_q[h]) begin
            taken_q[h] = 1'b1;
            owner_q[h] = me;
            depth_q[h] = DEPTH_BITS_DEF'(1);
          end else begin
            o.status = ST_BUSY;
          end
        end
        OP_UNLOCK: begin
          if (!owns(h, me)) begin
            o.status = ST_MISUSE;
          end else if (depth_q[h] > 1) begin
            depth_q[h] = depth_q[h] - 1'b1;
          end else begin
            taken_q[h] = 1'b0;
            owner_q[h] = '0;
            depth_q[h] = '0;
          end
        end
        default: ;
      endcase
      o.held = owns(h, me);
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q    = '{default: 1'b0};
      taken_q     = '{default: 1'b0};
      owner_q     = '{default: '0};
      depth_q     = '{default: '0};
      recursive_q = '{default: 1'b0};
      expected_rsp_q.delete();
    end else begin
      // Retire the result first: a new item may be taken at the same edge.
      if (done_i) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t unexpected result: expected none, got %p", $time, rsp_i);
          fails++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_i.status !== want.status) begin
            $display("%0t status: expected %0d, got %0d", $time, want.status, rsp_i.status);
            fails++;
          end
          if (rsp_i.handle_out !== want.handle_out) begin
            $display("%0t handle_out: expected %0d, got %0d", $time, want.handle_out,
                     rsp_i.handle_out);
            fails++;
          end
          if (rsp_i.held !== want.held) begin
            $display("%0t held: expected %0d, got %0d", $time, want.held, rsp_i.held);
            fails++;
          end
        end
      end
      if (start && !busy) expected_rsp_q.push_back(predict_outcome(req_i));
    end
    waiting = expected_rsp_q.size();
  end

endmodule

// ----- dv/recursive_mutex_pool_tb.sv -----
// Top of the recursive mutex pool testbench: stimulus, watchdog and verdict.
module recursive_mutex_pool_tb;
  import rmp_pkg::*;

  // Operation codes outside the defined set; the block must flag them.
  localparam logic [OP_W-1:0] OP_UNDEF_5 = OP_W'(5);
  localparam logic [OP_W-1:0] OP_UNDEF_6 = OP_W'(6);
  localparam logic [OP_W-1:0] OP_UNDEF_7 = OP_W'(7);

  localparam int ENTRIES      = POOL_SLOTS_DEF + STATIC_SLOTS_DEF;
  localparam int DEPTH_MAX    = (1 << DEPTH_BITS_DEF) - 1;
  localparam int RANDOM_ITEMS = 850;
  // Longest quiet stretch is a long sender gap plus the block's latency.
  localparam int IDLE_LIMIT   = 1000;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  rmp_req_t req_i  = '0;
  logic     done_o;
  rmp_rsp_t rsp_o;

  int          n_fail;
  int          n_pending;
  int unsigned sent   = 0;
  bit          steady = 1'b0;   // when set, the sender never idles
  logic [TID_W-1:0] crew [4];   // small set of threads so that locks collide

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  recursive_mutex_pool dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  recursive_mutex_pool_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .done_i        (done_o),
    .rsp_i         (rsp_o),
    .fail_count_o  (n_fail),
    .outstanding_o (n_pending)
  );

  // Mostly back-to-back, sometimes a short gap, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (steady || roll < 60) return 0;
    if (roll < 92) return $urandom_range(4, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [TID_W-1:0] pick_tid();
    if ($urandom_range(99) < 85) return crew[$urandom_range(3)];
    return TID_W'($urandom_range(255));
  endfunction

  // Favour a few hot entries so that locks pile up on the same mutex.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 20) return HANDLE_W'($urandom_range(3));
    if (roll < 40) return HANDLE_W'(POOL_SLOTS_DEF + $urandom_range(3));
    if (roll < 92) return HANDLE_W'($urandom_range(ENTRIES - 1));
    return HANDLE_W'($urandom_range((1 << HANDLE_W) - 1, ENTRIES));
  endfunction

  // Present one item, hold it until the block takes it, then sometimes idle a while.
  task automatic issue(input logic [OP_W-1:0] op, input logic [KIND_W-1:0] knd,
                       input logic [HANDLE_W-1:0] hdl, input logic [TID_W-1:0] tid);
    rmp_req_t    r;
    int unsigned gap;
    r.operation = op;
    r.kind      = knd;
    r.handle    = hdl;
    r.thread_id = tid;
    req_i <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sent++;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (n_pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Lock a mutex a few times, let a rival and a query cut in, then unwind;
  // sometimes unlock once too often.
  task automatic nest_sequence();
    logic [HANDLE_W-1:0] h;
    logic [TID_W-1:0]    owner;
    logic [TID_W-1:0]    rival;
    int unsigned         n;
    h     = pick_handle();
    owner = pick_tid();
    rival = pick_tid();
    n     = $urandom_range(4, 1);
    if (h >= POOL_SLOTS_DEF && h < ENTRIES && $urandom_range(1) == 1)
      issue(OP_ALLOC, STATIC_FIRST_KIND + KIND_W'(h - POOL_SLOTS_DEF),
            HANDLE_W'($urandom_range(63)), owner);
    repeat (n) begin
      issue(OP_LOCK, KIND_W'($urandom_range(15)), h, owner);
      if ($urandom_range(3) == 0) issue(OP_LOCK, KIND_W'($urandom_range(15)), h, rival);
      if ($urandom_range(3) == 0)
        issue(OP_HELD, KIND_W'($urandom_range(15)), h, $urandom_range(1) ? owner : rival);
    end
    if ($urandom_range(3) == 0) n++;
    repeat (n) issue(OP_UNLOCK, KIND_W'($urandom_range(15)), h, owner);
  endtask

  task automatic alloc_burst();
    logic [KIND_W-1:0] knd;
    repeat ($urandom_range(5, 1)) begin
      knd = ($urandom_range(99) < 70) ? KIND_W'($urandom_range(1))
                                      : KIND_W'($urandom_range(15));
      issue(OP_ALLOC, knd, HANDLE_W'($urandom_range(63)), pick_tid());
    end
  endtask

  // Watchdog: end the run if nothing moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) quiet = 0;
      else quiet++;
    end
    $display("recursive_mutex_pool: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [TID_W-1:0] ta;
    logic [TID_W-1:0] tb;
    int unsigned      roll;
    for (int i = 0; i < 4; i++) crew[i] = TID_W'($urandom_range(255));
    ta = 8'h5A;
    tb = 8'hA5;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: fresh state, lock corner cases, every alloc flavour.
    issue(OP_HELD,   KIND_FAST, 6'd0, 8'h00);           // nothing held after reset
    issue(OP_LOCK,   KIND_FAST, 6'd5, ta);              // lock a slot never allocated
    issue(OP_LOCK,   KIND_FAST, 6'd5, ta);              // owner relock, not recursive
    issue(OP_LOCK,   KIND_FAST, 6'd5, tb);              // contention
    issue(OP_UNLOCK, KIND_FAST, 6'd5, tb);              // unlock by another owner
    issue(OP_UNLOCK, KIND_FAST, 6'd5, ta);
    issue(OP_UNLOCK, KIND_FAST, 6'd5, ta);              // unlock of a free mutex
    issue(OP_ALLOC,  KIND_FAST,      6'd63, 8'hFF);
    issue(OP_ALLOC,  KIND_RECURSIVE, 6'd0,  8'hFF);
    issue(OP_LOCK,   KIND_FAST, 6'd1, 8'hFF);
    issue(OP_LOCK,   KIND_FAST, 6'd1, 8'hFF);           // nest to depth two
    issue(OP_HELD,   KIND_FAST, 6'd1, 8'hFF);
    issue(OP_UNLOCK, KIND_FAST, 6'd1, 8'hFF);
    issue(OP_ALLOC,  STATIC_FIRST_KIND,               6'd0, 8'h00);
    issue(OP_ALLOC,  STATIC_FIRST_KIND + 4'd11,       6'd0, 8'h01);  // last static
    issue(OP_ALLOC,  KIND_W'((1 << KIND_W) - 1),      6'd0, 8'h80);  // clamps to first
    issue(OP_ALLOC,  STATIC_FIRST_KIND + 4'd12,       6'd0, 8'h7F);  // just past the range
    issue(OP_FREE,   KIND_FAST, HANDLE_W'(POOL_SLOTS_DEF), 8'h00);   // static: no effect
    issue(OP_FREE,   KIND_FAST, 6'd1, 8'hFF);           // free leaves the lock alone
    issue(OP_HELD,   KIND_FAST, 6'd63, 8'hFF);          // handles beyond the last entry
    issue(OP_LOCK,   KIND_FAST, HANDLE_W'(ENTRIES), 8'hFF);
    issue(OP_UNDEF_5, KIND_FAST, 6'd2, 8'h11);
    issue(OP_UNDEF_6, KIND_FAST, 6'd2, 8'h22);
    issue(OP_UNDEF_7, KIND_FAST, 6'd2, 8'h33);
    drain();

    sent = 0;

    // Fill the pool until it runs dry a couple of times.
    repeat (POOL_SLOTS_DEF + 1)
      issue(OP_ALLOC, KIND_W'($urandom_range(1)), HANDLE_W'($urandom_range(63)), pick_tid());

    // Nest one static mutex past the largest depth, then unwind past zero.
    drain();
    ta = pick_tid();
    issue(OP_ALLOC, STATIC_FIRST_KIND + 4'd10, 6'd0, ta);
    steady = 1'b1;
    repeat (DEPTH_MAX + 1)
      issue(OP_LOCK, KIND_W'($urandom_range(15)), HANDLE_W'(POOL_SLOTS_DEF + 10), ta);
    steady = 1'b0;
    repeat (DEPTH_MAX + 1)
      issue(OP_UNLOCK, KIND_W'($urandom_range(15)), HANDLE_W'(POOL_SLOTS_DEF + 10), ta);

    // Random mix: mostly lock nests and alloc/free traffic, some noise.
    while (sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(3) == 0);
      roll   = $urandom_range(99);
      if (roll < 45) begin
        nest_sequence();
      end else if (roll < 65) begin
        alloc_burst();
      end else if (roll < 80) begin
        repeat ($urandom_range(3, 1))
          issue(OP_FREE, KIND_W'($urandom_range(15)), pick_handle(), pick_tid());
      end else if (roll < 88) begin
        issue(OP_HELD, KIND_W'($urandom_range(15)), pick_handle(), pick_tid());
      end else if (roll < 97) begin
        repeat ($urandom_range(3, 1))
          issue(OP_W'($urandom_range(7)), KIND_W'($urandom_range(15)),
                HANDLE_W'($urandom_range(63)), TID_W'($urandom_range(255)));
      end else begin
        drain();
      end
    end
    steady = 1'b0;

    // Wait out the stragglers, then a few more cycles for stray strobes.
    drain();
    repeat (8) @(posedge clk_i);
    if (n_fail == 0 && n_pending == 0) begin
      $display("recursive_mutex_pool: match");
    end else begin
      $display("recursive_mutex_pool: mismatch");
    end
    $finish;
  end

endmodule
